FILE: design/mpls_pkg.sv
// shared widths, coefficients, register indexes and types for the power limit scaler
package mpls_pkg;

   // wheel count is tied to the named per-wheel ports
   localparam int WHEEL_COUNT     = 4;
   localparam int SCALE_FRAC_BITS = 14;

   // field widths
   localparam int CUR_W      = 16;
   localparam int SPD_W      = 16;
   localparam int MV_W       = 15;
   localparam int EST_W      = 17;
   localparam int ALW_W      = 16;
   localparam int SCALE_W    = 15;
   localparam int BUDGET_W   = 10;
   localparam int BIAS_W     = 15;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_POWER_BUDGET = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_BIAS   = 4'd1;

   localparam logic [BUDGET_W-1:0] BUDGET_RST = 10'd60;
   localparam logic [BIAS_W-1:0]   BIAS_RST   = 15'd246;

   // pipeline depths
   localparam int LANE_STAGES  = 4;
   localparam int MERGE_STAGES = 3;

   // per-wheel power terms, units of 2^-40 W
   localparam int PROD_W = 32;
   localparam int TERM_W = 54;
   localparam int ABS_W  = 53;
   localparam logic signed [TERM_W-1:0] COEF_KT = 54'sd2195604;
   localparam logic signed [TERM_W-1:0] COEF_K2 = 54'sd159759;
   localparam logic signed [TERM_W-1:0] COEF_KA = 54'sd135240;
   localparam logic signed [TERM_W-1:0] COEF_C  = 54'sd4487106952954;

   // estimate: round(sum * 20 / (17 * 2^36)) in 1/16 W
   localparam int SUM_W       = ABS_W + $clog2(WHEEL_COUNT);
   localparam int X_W         = SUM_W + 5;
   localparam int EST_SHIFT   = 36;
   localparam int Y_FULL_W    = X_W - EST_SHIFT;
   localparam int Y_W         = 22;
   localparam logic [X_W-1:0]      ROUND_ADD = X_W'(64'd584115552256);
   localparam logic [Y_FULL_W-1:0] Y_SAT     = Y_FULL_W'(2228224);
   localparam int DIV17_MULT_W = 23;
   localparam logic [DIV17_MULT_W-1:0] DIV17_MULT = 23'd7895161;
   localparam int DIV17_SHIFT = 27;
   localparam logic [EST_W-1:0] EST_MAX = '1;

   // budget from capacitor voltage
   localparam logic [MV_W-1:0] MV_LOW_MAX = 15'd6000;
   localparam int MV_PROD_W = 23;
   localparam logic [MV_PROD_W-1:0] GAIN_BOOST = 23'd240;
   localparam logic [MV_PROD_W-1:0] GAIN_BASE  = 23'd224;
   localparam int DIV1000_MULT_W = 24;
   localparam logic [DIV1000_MULT_W-1:0] DIV1000_MULT = 24'd8589935;
   localparam int DIV1000_SHIFT = 33;
   localparam int MV_Q_W = 13;
   localparam logic signed [ALW_W-1:0] ALW_LOW_OFS = 16'sd32;

   localparam logic [SCALE_W-1:0] SCALE_MAX = '1;

   // word handed from the merge stage to the divider
   typedef struct packed {
      logic [EST_W-1:0]        est;
      logic signed [ALW_W-1:0] allowed;
   } div_req_type;

endpackage

FILE: design/motor_power_limit_scaler.sv
// motor power limit scaler top level: lanes, budget, merge and divider
//
// usage
//   req_ channel: one word per control step with four wheel currents, four
//   wheel speeds, capacitor voltage in mV and the boost flag
//   rsp_ channel: one word per request with the Q1.14 current scale, the
//   summed power estimate in 1/16 W and the power budget in 1/16 W
//   csr_ channel: index 0 writes the power limit in watts, index 1 the bias;
//   other indexes are dropped; csr_ready is always high
// timing
//   a word passes the lane and budget stages, then the merge stages, then
//   the iterative divider and its output register; the shared iterative
//   divider at the end takes a new word only once it has finished the last
//   one, so it sets the throughput
// reset
//   clears all pipeline valids and the output valid, loads 60 W and bias 246
// stalls
//   the response is held in an output register while rsp_ready is low; the
//   divider holds its finished word and the pipeline in front moves on until
//   its last stage holds a word the divider cannot take; then req_ready drops
module motor_power_limit_scaler #(
   parameter int SCALE_FRAC_BITS = mpls_pkg::SCALE_FRAC_BITS
) (
   input  logic                                      clock,
   input  logic                                      reset,
   // request words
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic signed [mpls_pkg::CUR_W-1:0]         req_current_fr,
   input  logic signed [mpls_pkg::CUR_W-1:0]         req_current_fl,
   input  logic signed [mpls_pkg::CUR_W-1:0]         req_current_bl,
   input  logic signed [mpls_pkg::CUR_W-1:0]         req_current_br,
   input  logic signed [mpls_pkg::SPD_W-1:0]         req_speed_fr,
   input  logic signed [mpls_pkg::SPD_W-1:0]         req_speed_fl,
   input  logic signed [mpls_pkg::SPD_W-1:0]         req_speed_bl,
   input  logic signed [mpls_pkg::SPD_W-1:0]         req_speed_br,
   input  logic        [mpls_pkg::MV_W-1:0]          req_cap_voltage_mv,
   input  logic                                      req_boost_on,
   // response words
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic        [mpls_pkg::SCALE_W-1:0]       rsp_scale_q14,
   output logic        [mpls_pkg::EST_W-1:0]         rsp_estimated_power,
   output logic signed [mpls_pkg::ALW_W-1:0]         rsp_allowed_power,
   // register writes
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic        [mpls_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic        [mpls_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int NSTG = mpls_pkg::LANE_STAGES + mpls_pkg::MERGE_STAGES;

   // configuration registers
   logic [mpls_pkg::BUDGET_W-1:0] budget_ff;
   logic [mpls_pkg::BIAS_W-1:0]   bias_ff;

   // pipeline occupancy, one bit per stage
   logic [NSTG-1:0] vld_ff, vld_in;
   logic            en;
   logic            div_ready;

   logic signed [mpls_pkg::CUR_W-1:0] cur [mpls_pkg::WHEEL_COUNT];
   logic signed [mpls_pkg::SPD_W-1:0] spd [mpls_pkg::WHEEL_COUNT];
   logic        [mpls_pkg::ABS_W-1:0] mag [mpls_pkg::WHEEL_COUNT];
   logic signed [mpls_pkg::ALW_W-1:0] allowed;
   mpls_pkg::div_req_type             div_req;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff <= mpls_pkg::BUDGET_RST;
         bias_ff   <= mpls_pkg::BIAS_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            mpls_pkg::CSR_POWER_BUDGET: budget_ff <= csr_wdata[mpls_pkg::BUDGET_W-1:0];
            mpls_pkg::CSR_SCALE_BIAS:   bias_ff   <= csr_wdata[mpls_pkg::BIAS_W-1:0];
            default: ;
         endcase
      end
   end

   // whole pipeline moves together; it stops only when the last stage
   // holds a word the divider cannot take
   assign en        = !vld_ff[NSTG-1] || div_ready;
   assign req_ready = en;
   assign vld_in    = {vld_ff[NSTG-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // wheel order: front right, front left, back left, back right
   assign cur[0] = req_current_fr;
   assign cur[1] = req_current_fl;
   assign cur[2] = req_current_bl;
   assign cur[3] = req_current_br;
   assign spd[0] = req_speed_fr;
   assign spd[1] = req_speed_fl;
   assign spd[2] = req_speed_bl;
   assign spd[3] = req_speed_br;

   for (genvar g = 0; g < mpls_pkg::WHEEL_COUNT; g++) begin : g_lane
      mpls_lane u_lane (
         .clock   (clock),
         .en      (en),
         .current (cur[g]),
         .speed   (spd[g]),
         .mag     (mag[g])
      );
   end

   // budget runs alongside the lanes with the same depth
   mpls_budget u_budget (
      .clock    (clock),
      .en       (en),
      .mv       (req_cap_voltage_mv),
      .boost    (req_boost_on),
      .budget_w (budget_ff),
      .allowed  (allowed)
   );

   mpls_merge u_merge (
      .clock   (clock),
      .en      (en),
      .mag     (mag),
      .allowed (allowed),
      .req     (div_req)
   );

   mpls_div #(
      .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
   ) u_div (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (vld_ff[NSTG-1]),
      .in_ready    (div_ready),
      .in_req      (div_req),
      .bias        (bias_ff),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .out_scale   (rsp_scale_q14),
      .out_est     (rsp_estimated_power),
      .out_allowed (rsp_allowed_power)
   );

endmodule

FILE: design/mpls_lane.sv
// one wheel lane: power terms, sum and magnitude over four stages
module mpls_lane (
   input  logic                               clock,
   input  logic                               en,
   input  logic signed [mpls_pkg::CUR_W-1:0]  current,
   input  logic signed [mpls_pkg::SPD_W-1:0]  speed,
   output logic        [mpls_pkg::ABS_W-1:0]  mag
);

   logic signed [mpls_pkg::PROD_W-1:0] iw_ff, iw_in, ww_ff, ww_in, ii_ff, ii_in;
   logic signed [mpls_pkg::TERM_W-1:0] a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic signed [mpls_pkg::TERM_W-1:0] t_ff, t_in;
   logic        [mpls_pkg::ABS_W-1:0]  mag_ff, mag_in;

   assign iw_in = current * speed;
   assign ww_in = speed * speed;
   assign ii_in = current * current;

   assign a_in = iw_ff * mpls_pkg::COEF_KT;
   assign b_in = ww_ff * mpls_pkg::COEF_K2;
   assign c_in = ii_ff * mpls_pkg::COEF_KA;

   assign t_in = a_ff + b_ff + c_ff + mpls_pkg::COEF_C;

   // only the current-speed term can go negative
   assign mag_in = t_ff[mpls_pkg::TERM_W-1] ? mpls_pkg::ABS_W'(-t_ff)
                                            : mpls_pkg::ABS_W'(t_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         iw_ff  <= iw_in;
         ww_ff  <= ww_in;
         ii_ff  <= ii_in;
         a_ff   <= a_in;
         b_ff   <= b_in;
         c_ff   <= c_in;
         t_ff   <= t_in;
         mag_ff <= mag_in;
      end
   end

   assign mag = mag_ff;

endmodule

FILE: design/mpls_budget.sv
// power budget from configured limit and capacitor voltage, four stages
module mpls_budget (
   input  logic                                  clock,
   input  logic                                  en,
   input  logic        [mpls_pkg::MV_W-1:0]      mv,
   input  logic                                  boost,
   input  logic        [mpls_pkg::BUDGET_W-1:0]  budget_w,
   output logic signed [mpls_pkg::ALW_W-1:0]     allowed
);

   localparam int PW = mpls_pkg::MV_PROD_W + mpls_pkg::DIV1000_MULT_W;

   logic [mpls_pkg::MV_PROD_W-1:0] p_ff, p_in;
   logic [PW-1:0]                  prod_ff, prod_in;
   logic [mpls_pkg::MV_Q_W-1:0]    q_ff, q_in;
   logic                           low1_ff, low1_in, low2_ff, low3_ff;
   logic signed [mpls_pkg::ALW_W-1:0] base;
   logic signed [mpls_pkg::ALW_W-1:0] allowed_ff, allowed_in;

   assign p_in = mpls_pkg::MV_PROD_W'(mv)
               * (boost ? mpls_pkg::GAIN_BOOST : mpls_pkg::GAIN_BASE);
   assign low1_in = (mv <= mpls_pkg::MV_LOW_MAX);

   // floor(p / 1000) by reciprocal multiply
   assign prod_in = PW'(p_ff) * PW'(mpls_pkg::DIV1000_MULT);
   assign q_in    = prod_ff[mpls_pkg::DIV1000_SHIFT +: mpls_pkg::MV_Q_W];

   assign base = $signed(mpls_pkg::ALW_W'({budget_w, 4'b0000}));
   assign allowed_in = low3_ff ? base - mpls_pkg::ALW_LOW_OFS
                               : base + $signed(mpls_pkg::ALW_W'(q_ff));

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff       <= p_in;
         low1_ff    <= low1_in;
         prod_ff    <= prod_in;
         low2_ff    <= low1_ff;
         q_ff       <= q_in;
         low3_ff    <= low2_ff;
         allowed_ff <= allowed_in;
      end
   end

   assign allowed = allowed_ff;

endmodule

FILE: design/mpls_merge.sv
// sums the lane magnitudes and forms the saturated estimate in 1/16 W
module mpls_merge (
   input  logic                                   clock,
   input  logic                                   en,
   input  logic [mpls_pkg::ABS_W-1:0]             mag [mpls_pkg::WHEEL_COUNT],
   input  logic signed [mpls_pkg::ALW_W-1:0]      allowed,
   output mpls_pkg::div_req_type                  req
);

   localparam int MW = mpls_pkg::Y_W + mpls_pkg::DIV17_MULT_W;

   logic [mpls_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic [mpls_pkg::X_W-1:0]      x;
   logic [mpls_pkg::Y_FULL_W-1:0] y;
   logic [mpls_pkg::Y_W-1:0]      yl_ff, yl_in;
   logic                          sat_ff, sat_in;
   logic [MW-1:0]                 prod;
   logic [mpls_pkg::EST_W-1:0]    est_ff, est_in;
   logic signed [mpls_pkg::ALW_W-1:0] alw1_ff, alw2_ff, alw3_ff;

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < mpls_pkg::WHEEL_COUNT; i++) begin
         sum_in = sum_in + mpls_pkg::SUM_W'(mag[i]);
      end
   end

   // sum * 20 plus half the divisor, then drop 2^36
   assign x = (mpls_pkg::X_W'(sum_ff) << 4) + (mpls_pkg::X_W'(sum_ff) << 2)
            + mpls_pkg::ROUND_ADD;
   assign y = x[mpls_pkg::X_W-1:mpls_pkg::EST_SHIFT];
   assign sat_in = (y >= mpls_pkg::Y_SAT);
   assign yl_in  = y[mpls_pkg::Y_W-1:0];

   // y / 17 by reciprocal multiply
   assign prod   = MW'(yl_ff) * MW'(mpls_pkg::DIV17_MULT);
   assign est_in = sat_ff ? mpls_pkg::EST_MAX
                          : prod[mpls_pkg::DIV17_SHIFT +: mpls_pkg::EST_W];

   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff  <= sum_in;
         alw1_ff <= allowed;
         yl_ff   <= yl_in;
         sat_ff  <= sat_in;
         alw2_ff <= alw1_ff;
         est_ff  <= est_in;
         alw3_ff <= alw2_ff;
      end
   end

   assign req.est     = est_ff;
   assign req.allowed = alw3_ff;

endmodule

FILE: design/mpls_div.sv
// iterative ratio divider, four quotient bits a cycle, with output register
module mpls_div #(
   parameter int SCALE_FRAC_BITS = mpls_pkg::SCALE_FRAC_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  mpls_pkg::div_req_type                 in_req,
   input  logic        [mpls_pkg::BIAS_W-1:0]    bias,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output logic        [mpls_pkg::SCALE_W-1:0]   out_scale,
   output logic        [mpls_pkg::EST_W-1:0]     out_est,
   output logic signed [mpls_pkg::ALW_W-1:0]     out_allowed
);

   localparam int STEPS = 4;
   localparam int QW    = ((SCALE_FRAC_BITS + STEPS) / STEPS) * STEPS;
   localparam int CYC   = QW / STEPS;
   localparam int CNT_W = (CYC > 1) ? $clog2(CYC) : 1;
   localparam int NW    = mpls_pkg::ALW_W - 1 + SCALE_FRAC_BITS;
   localparam int RW    = mpls_pkg::EST_W;
   localparam int VW    = ((QW > mpls_pkg::SCALE_W) ? QW : mpls_pkg::SCALE_W) + 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CYC - 1);

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_HOLD} state_type;

   state_type                         state_ff, state_in;
   logic [CNT_W-1:0]                  cnt_ff;
   logic [RW-1:0]                     rem_ff, rem_s;
   logic [QW-1:0]                     low_ff, low_s, quo_ff, quo_s, q_fin;
   logic [RW:0]                       trial;
   logic [mpls_pkg::EST_W-1:0]        div_ff;
   logic signed [mpls_pkg::ALW_W-1:0] alw_ff;
   logic                              full_ff, zero_ff;
   logic [NW-1:0]                     n_load;
   logic signed [mpls_pkg::EST_W:0]   alw_x, est_x;
   logic                              full_in;
   logic                              last, out_free, out_wr, load;
   logic [VW-1:0]                     val;
   logic [mpls_pkg::SCALE_W-1:0]      scale_in;
   logic                              out_valid_ff;
   logic [mpls_pkg::SCALE_W-1:0]      scale_ff;
   logic [mpls_pkg::EST_W-1:0]        est_out_ff;
   logic signed [mpls_pkg::ALW_W-1:0] alw_out_ff;

   // restoring steps for one cycle
   always_comb begin
      rem_s = rem_ff;
      low_s = low_ff;
      quo_s = quo_ff;
      trial = '0;
      for (int i = 0; i < STEPS; i++) begin
         trial = {rem_s, low_s[QW-1]};
         if (trial >= {1'b0, div_ff}) begin
            rem_s = RW'(trial - {1'b0, div_ff});
            quo_s = {quo_s[QW-2:0], 1'b1};
         end else begin
            rem_s = trial[RW-1:0];
            quo_s = {quo_s[QW-2:0], 1'b0};
         end
         low_s = {low_s[QW-2:0], 1'b0};
      end
   end

   // dividend is allowed * 2^frac; if allowed exceeds the estimate or the estimate is zero, the scale is forced to one
   assign n_load  = {in_req.allowed[mpls_pkg::ALW_W-2:0], {SCALE_FRAC_BITS{1'b0}}};
   assign alw_x   = (mpls_pkg::EST_W+1)'(in_req.allowed);
   assign est_x   = $signed({1'b0, in_req.est});
   assign full_in = (in_req.est == '0) || (alw_x > est_x);

   assign last     = (state_ff == ST_RUN) && (cnt_ff == '0);
   assign out_free = !out_valid_ff || out_ready;
   assign out_wr   = (last || (state_ff == ST_HOLD)) && out_free;
   assign in_ready = (state_ff == ST_IDLE) || out_wr;
   assign load     = in_valid && in_ready;

   assign q_fin = (state_ff == ST_RUN) ? quo_s : quo_ff;

   always_comb begin
      if (full_ff) begin
         val = VW'(1) << SCALE_FRAC_BITS;
      end else if (zero_ff) begin
         val = '0;
      end else if (VW'(q_fin) > VW'(bias)) begin
         val = VW'(q_fin) - VW'(bias);
      end else begin
         val = '0;
      end
      if (val > VW'(mpls_pkg::SCALE_MAX)) begin
         scale_in = mpls_pkg::SCALE_MAX;
      end else begin
         scale_in = val[mpls_pkg::SCALE_W-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (load) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (load)          state_in = ST_RUN;
            else if (out_wr)   state_in = ST_IDLE;
            else if (last)     state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (load)          state_in = ST_RUN;
            else if (out_wr)   state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_wr) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (load) begin
         cnt_ff  <= CNT_LAST;
         rem_ff  <= RW'(n_load >> QW);
         low_ff  <= n_load[QW-1:0];
         quo_ff  <= '0;
         div_ff  <= in_req.est;
         alw_ff  <= in_req.allowed;
         full_ff <= full_in;
         zero_ff <= in_req.allowed[mpls_pkg::ALW_W-1];
      end else if (state_ff == ST_RUN) begin
         cnt_ff <= cnt_ff - 1'b1;
         rem_ff <= rem_s;
         low_ff <= low_s;
         quo_ff <= quo_s;
      end
      if (out_wr) begin
         scale_ff   <= scale_in;
         est_out_ff <= div_ff;
         alw_out_ff <= alw_ff;
      end
   end

   assign out_valid   = out_valid_ff;
   assign out_scale   = scale_ff;
   assign out_est     = est_out_ff;
   assign out_allowed = alw_out_ff;

endmodule
